FILE: rtl/radix_digit_converter_top_defines.svh
// Assertion macros shared by the converter RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RADIX_DIGIT_CONVERTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radix converter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radix converter assertion failed");

`endif

FILE: rtl/rdc_pkg.sv
package rdc_pkg;

	localparam int VALUE_W    = 60;
	localparam int RES_W      = 31;
	localparam int BCD_DIGITS = 19;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int EXP_W      = 6;

	localparam logic [RES_W-1:0] LIMIT = 31'h7FFF_FFFF;

	typedef logic [2:0] func_t;

	localparam func_t FN_BIN_DEC = 3'd0;
	localparam func_t FN_DEC_BIN = 3'd1;
	localparam func_t FN_OCT_DEC = 3'd2;
	localparam func_t FN_DEC_OCT = 3'd3;
	localparam func_t FN_BIN_OCT = 3'd4;
	localparam func_t FN_OCT_BIN = 3'd5;

endpackage

FILE: rtl/radix_digit_converter_top.sv
// Radix converter between binary, octal and decimal, where binary and octal numbers are
// carried as integers whose decimal digits are the base digits. One item is worked on at a
// time and in_stall stays high until its result has moved into the output register. A mode
// that reads digits first splits the input into decimal digits with a bit-serial
// binary-to-BCD shifter, then weights one decimal digit per cycle. A mode that writes digits
// emits one base digit per cycle through the multiply-add-compare unit. Each mode ends early
// when the 2^31-1 limit is passed, and the done state hands the result over to the output
// register. Unused selectors go straight to the done state.
`include "radix_digit_converter_top_defines.svh"

module radix_digit_converter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rdc_pkg::func_t                   func,
	input  logic [rdc_pkg::VALUE_W-1:0]      value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rdc_pkg::RES_W-1:0]        converted,
	output logic                             overflow
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BCD   = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                       state_q;
	rdc_pkg::func_t                   func_q;
	logic [rdc_pkg::VALUE_W-1:0]      bin_q;
	logic [rdc_pkg::BCD_W-1:0]        bcd_q;
	logic [5:0]                       cnt_q;
	logic [rdc_pkg::EXP_W-1:0]        exp_q;
	logic [rdc_pkg::RES_W-1:0]        acc_q;
	logic [rdc_pkg::RES_W-1:0]        w_q;
	logic                             wbig_q;
	logic                             ovf_q;
	logic                             out_valid_q;
	logic [rdc_pkg::RES_W-1:0]        converted_q;
	logic                             overflow_q;

	logic                             in_accept;
	logic                             out_load;
	logic                             read_oct;
	logic                             write_bin;
	logic                             chain_mode;
	logic [rdc_pkg::BCD_W-1:0]        bcd_adj;
	logic [3:0]                       rd_digit;
	logic [34:0]                      rd_term;
	logic [35:0]                      rd_sum;
	logic                             rd_over;
	logic [2:0]                       wr_digit;
	logic [33:0]                      wr_prod;
	logic [34:0]                      wr_sum;
	logic [34:0]                      w_times10;
	logic                             wr_over;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign read_oct   = (func_q == rdc_pkg::FN_OCT_DEC) || (func_q == rdc_pkg::FN_OCT_BIN);
	assign write_bin  = (func_q == rdc_pkg::FN_DEC_BIN) || (func_q == rdc_pkg::FN_OCT_BIN);
	assign chain_mode = (func_q == rdc_pkg::FN_BIN_OCT) || (func_q == rdc_pkg::FN_OCT_BIN);

	// Add-3 correction on every BCD digit before the next binary bit shifts in.
	always_comb begin
		for (int i = 0; i < rdc_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Reading: the weight is a power of two, so the digit is shifted into place.
	assign rd_digit = bcd_q[3:0];
	assign rd_term  = 35'(rd_digit) << exp_q;
	assign rd_sum   = 36'(acc_q) + 36'(rd_term);
	assign rd_over  = (rd_digit != 4'd0) &&
	                  ((exp_q >= 6'(rdc_pkg::RES_W)) || (rd_sum > 36'(rdc_pkg::LIMIT)));

	// Writing: the weight is a power of ten, kept until it passes the limit.
	assign wr_digit  = write_bin ? {2'b00, bin_q[0]} : bin_q[2:0];
	assign wr_prod   = 34'(wr_digit) * 34'(w_q);
	assign wr_sum    = 35'(acc_q) + 35'(wr_prod);
	assign w_times10 = {1'b0, w_q, 3'b000} + {3'b000, w_q, 1'b0};
	assign wr_over   = (wr_digit != 3'd0) && (wbig_q || (wr_sum > 35'(rdc_pkg::LIMIT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (func == rdc_pkg::FN_DEC_BIN || func == rdc_pkg::FN_DEC_OCT) begin
							state_q <= S_WRITE;
						end else if (func == rdc_pkg::FN_BIN_DEC || func == rdc_pkg::FN_OCT_DEC ||
						             func == rdc_pkg::FN_BIN_OCT || func == rdc_pkg::FN_OCT_BIN) begin
							state_q <= S_BCD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_BCD: begin
					if (cnt_q == 6'(rdc_pkg::VALUE_W - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (bcd_q == '0) begin
						state_q <= chain_mode ? S_WRITE : S_DONE;
					end else if (rd_over) begin
						state_q <= S_DONE;
					end
				end
				S_WRITE: begin
					if (bin_q == '0 || wr_over) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				bin_q  <= value;
				bcd_q  <= '0;
				cnt_q  <= '0;
				exp_q  <= '0;
				acc_q  <= '0;
				w_q    <= 31'd1;
				wbig_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
			S_BCD: begin
				bcd_q <= {bcd_adj[rdc_pkg::BCD_W-2:0], bin_q[rdc_pkg::VALUE_W-1]};
				bin_q <= {bin_q[rdc_pkg::VALUE_W-2:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			S_READ: begin
				if (bcd_q == '0) begin
					// The plain integer becomes the number to write out.
					bin_q <= rdc_pkg::VALUE_W'(acc_q);
					if (chain_mode) begin
						acc_q <= '0;
					end
				end else if (rd_over) begin
					ovf_q <= 1'b1;
				end else begin
					acc_q <= rd_sum[rdc_pkg::RES_W-1:0];
					bcd_q <= bcd_q >> 4;
					exp_q <= exp_q + (read_oct ? 6'd3 : 6'd1);
				end
			end
			S_WRITE: begin
				if (bin_q != '0) begin
					if (wr_over) begin
						ovf_q <= 1'b1;
					end else begin
						acc_q <= wr_sum[rdc_pkg::RES_W-1:0];
						bin_q <= write_bin ? (bin_q >> 1) : (bin_q >> 3);
						if (!wbig_q) begin
							if (w_times10 > 35'(rdc_pkg::LIMIT)) begin
								wbig_q <= 1'b1;
							end else begin
								w_q <= w_times10[rdc_pkg::RES_W-1:0];
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			converted_q <= ovf_q ? rdc_pkg::LIMIT : acc_q;
			overflow_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign converted = converted_q;
	assign overflow  = overflow_q;

	`RDC_ASSERT_SAME(a_ovf_saturates, out_valid && overflow, converted == rdc_pkg::LIMIT)

	`RDC_ASSERT_SAME(a_read_mode, state_q == S_READ || state_q == S_BCD,
		func_q == rdc_pkg::FN_BIN_DEC || func_q == rdc_pkg::FN_OCT_DEC ||
		func_q == rdc_pkg::FN_BIN_OCT || func_q == rdc_pkg::FN_OCT_BIN)

	`RDC_ASSERT_SAME(a_write_mode, state_q == S_WRITE,
		func_q == rdc_pkg::FN_DEC_BIN || func_q == rdc_pkg::FN_DEC_OCT ||
		func_q == rdc_pkg::FN_BIN_OCT || func_q == rdc_pkg::FN_OCT_BIN)

	`RDC_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall)

endmodule

FILE: tb/sv/tb_radix_digit_converter_top.sv
module tb_radix_digit_converter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned PHASE_ITEMS = 450;
	localparam logic [63:0] RADIX_DEC = 64'd10;
	localparam logic [63:0] RADIX_BIN = 64'd2;
	localparam logic [63:0] RADIX_OCT = 64'd8;
	localparam logic [63:0] LIMIT_64  = 64'(rdc_pkg::LIMIT);

	typedef struct packed {
		rdc_pkg::func_t              op;
		logic [rdc_pkg::VALUE_W-1:0] num;
	} conv_item_t;

	typedef struct packed {
		logic [rdc_pkg::RES_W-1:0] converted;
		logic                      ovf;
	} conv_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	rdc_pkg::func_t              func = rdc_pkg::FN_BIN_DEC;
	logic [rdc_pkg::VALUE_W-1:0] value = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [rdc_pkg::RES_W-1:0]   converted;
	logic                        overflow;

	conv_item_t   pending_conversions[$];
	conv_result_t predicted_results[$];
	conv_item_t   next_item;
	conv_result_t oldest_result;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           failures = 0;

	radix_digit_converter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.converted (converted),
		.overflow  (overflow)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Reads the decimal digits of v as digits in base; the sum is exact in 64 bits.
	function automatic logic [63:0] read_base_digits(logic [63:0] v, logic [63:0] base,
			inout bit sat);
		logic [63:0] acc;
		logic [63:0] w;
		acc = '0;
		w = 64'd1;
		while (v != 0) begin
			acc += (v % RADIX_DEC) * w;
			w *= base;
			v /= RADIX_DEC;
		end
		if (acc > LIMIT_64) begin
			sat = 1'b1;
			acc = LIMIT_64;
		end
		return acc;
	endfunction

	// Writes v in base with each digit at the next power of ten, saturating at the limit.
	function automatic logic [63:0] write_base_digits(logic [63:0] v, logic [63:0] base,
			inout bit sat);
		logic [63:0] acc;
		logic [63:0] w;
		logic [63:0] d;
		acc = '0;
		w = 64'd1;
		while (v != 0) begin
			d = v % base;
			if (d != 0) begin
				if (w > LIMIT_64 || acc + d * w > LIMIT_64) begin
					sat = 1'b1;
					return LIMIT_64;
				end
				acc += d * w;
			end
			if (w <= LIMIT_64)
				w *= RADIX_DEC;
			v /= base;
		end
		return acc;
	endfunction

	function automatic conv_result_t convert_number(rdc_pkg::func_t op,
			logic [rdc_pkg::VALUE_W-1:0] num);
		conv_result_t res;
		logic [63:0]  plain;
		bit           sat;
		sat = 1'b0;
		plain = '0;
		case (op)
			rdc_pkg::FN_BIN_DEC: plain = read_base_digits(64'(num), RADIX_BIN, sat);
			rdc_pkg::FN_DEC_BIN: plain = write_base_digits(64'(num), RADIX_BIN, sat);
			rdc_pkg::FN_OCT_DEC: plain = read_base_digits(64'(num), RADIX_OCT, sat);
			rdc_pkg::FN_DEC_OCT: plain = write_base_digits(64'(num), RADIX_OCT, sat);
			rdc_pkg::FN_BIN_OCT: begin
				plain = read_base_digits(64'(num), RADIX_BIN, sat);
				plain = write_base_digits(plain, RADIX_OCT, sat);
			end
			rdc_pkg::FN_OCT_BIN: begin
				plain = read_base_digits(64'(num), RADIX_OCT, sat);
				plain = write_base_digits(plain, RADIX_BIN, sat);
			end
			default: plain = '0;
		endcase
		if (sat)
			plain = LIMIT_64;
		res.converted = plain[rdc_pkg::RES_W-1:0];
		res.ovf = sat;
		return res;
	endfunction

	function automatic rdc_pkg::func_t rand_func();
		if ($urandom_range(0, 19) == 0)
			return rdc_pkg::func_t'($urandom_range(6, 7));
		return rdc_pkg::func_t'($urandom_range(0, 5));
	endfunction

	// Mostly numbers that are well formed for the selected conversion, with some noise.
	function automatic logic [rdc_pkg::VALUE_W-1:0] rand_value(rdc_pkg::func_t op);
		logic [63:0] v;
		int          shape;
		int          ndig;
		int          digit_max;
		shape = $urandom_range(0, 9);
		v = '0;
		if (shape == 0) begin
			v = {$urandom, $urandom};
		end else if (op == rdc_pkg::FN_DEC_BIN || op == rdc_pkg::FN_DEC_OCT) begin
			if (shape < 6)
				v = {$urandom, $urandom} >> $urandom_range(30, 64);
			else
				v = {$urandom, $urandom} >> $urandom_range(4, 64);
		end else begin
			digit_max = (op == rdc_pkg::FN_BIN_DEC || op == rdc_pkg::FN_BIN_OCT) ? 1 : 7;
			if (shape == 1)
				digit_max = 9;
			ndig = (shape < 6) ? $urandom_range(1, 11) : $urandom_range(1, 18);
			for (int i = 0; i < ndig; i++)
				v = v * RADIX_DEC + 64'($urandom_range(0, digit_max));
		end
		return v[rdc_pkg::VALUE_W-1:0];
	endfunction

	task automatic queue_conversion(rdc_pkg::func_t op, logic [rdc_pkg::VALUE_W-1:0] num);
		conv_item_t it;
		it.op = op;
		it.num = num;
		pending_conversions.push_back(it);
	endtask

	// Driver: a new item is offered only once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= rdc_pkg::FN_BIN_DEC;
			value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				predicted_results.push_back(convert_number(func, value));
			if (pending_conversions.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				next_item = pending_conversions.pop_front();
				in_valid <= 1'b1;
				func <= next_item.op;
				value <= next_item.num;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$error("unexpected result: converted %0d, overflow %0d", converted, overflow);
					failures++;
				end else begin
					oldest_result = predicted_results.pop_front();
					if (converted !== oldest_result.converted) begin
						$error("converted: expected %0d, actual %0d",
							oldest_result.converted, converted);
						failures++;
					end
					if (overflow !== oldest_result.ovf) begin
						$error("overflow: expected %0d, actual %0d", oldest_result.ovf, overflow);
						failures++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Ends the run when no item moves on either side for too long.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("radix_digit_converter_top test failed");
		$finish;
	end

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		rdc_pkg::func_t op;
		phase_idle = '{0, 88, 0, 9};
		phase_stall = '{0, 0, 88, 9};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero, the widest input, digits above the base and the saturation boundaries.
		queue_conversion(rdc_pkg::FN_BIN_DEC, '0);
		queue_conversion(rdc_pkg::FN_BIN_DEC, 60'd1011);
		queue_conversion(rdc_pkg::FN_BIN_DEC, '1);
		queue_conversion(rdc_pkg::FN_BIN_DEC, 60'd999999999999999999);
		queue_conversion(rdc_pkg::FN_DEC_BIN, 60'd1023);
		queue_conversion(rdc_pkg::FN_DEC_BIN, 60'd1024);
		queue_conversion(rdc_pkg::FN_DEC_BIN, '1);
		queue_conversion(rdc_pkg::FN_OCT_DEC, '0);
		queue_conversion(rdc_pkg::FN_OCT_DEC, 60'd17777777777);
		queue_conversion(rdc_pkg::FN_OCT_DEC, 60'd20000000000);
		queue_conversion(rdc_pkg::FN_OCT_DEC, 60'd98);
		queue_conversion(rdc_pkg::FN_DEC_OCT, '0);
		queue_conversion(rdc_pkg::FN_DEC_OCT, 60'd123456789);
		queue_conversion(rdc_pkg::FN_DEC_OCT, 60'd1073741823);
		queue_conversion(rdc_pkg::FN_DEC_OCT, '1);
		queue_conversion(rdc_pkg::FN_BIN_OCT, '0);
		queue_conversion(rdc_pkg::FN_BIN_OCT, 60'd111111111111111111);
		queue_conversion(rdc_pkg::FN_BIN_OCT, 60'd1020);
		queue_conversion(rdc_pkg::FN_OCT_BIN, 60'd1777);
		queue_conversion(rdc_pkg::FN_OCT_BIN, 60'd2000);
		queue_conversion(rdc_pkg::FN_OCT_BIN, 60'd799);
		queue_conversion(rdc_pkg::func_t'(6), '0);
		queue_conversion(rdc_pkg::func_t'(7), '1);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				op = rand_func();
				queue_conversion(op, rand_value(op));
			end
			while (pending_conversions.size() != 0)
				@(negedge clk);
		end

		while (in_valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (failures == 0 && predicted_results.size() == 0) begin
			$display("radix_digit_converter_top test passed");
		end else begin
			$display("radix_digit_converter_top test failed");
		end
		$finish;
	end

endmodule
